// File: hw/rtl/assert_macros.svh
// assertion macros used by the odometry unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define DDO_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define DDO_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/ddo_pkg.sv
// types, constants and tables for the odometry unit
`timescale 1ns / 1ps

package ddo_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;

    localparam logic [15:0] WHEEL_RADIUS_RST  = 16'd2163;
    localparam logic [23:0] INVERSE_TRACK_RST = 24'd364089;
    localparam logic [25:0] TURN_SCALE        = 26'd44798134;
    localparam logic [33:0] CORDIC_GAIN       = 34'd652032874;
    localparam logic [28:0] DIST_DIV          = 29'd512000000;
    localparam logic [52:0] DIST_HALF         = 53'd256000000;
    // floor(2^60 / DIST_DIV)
    localparam logic [31:0] DIV_RECIP         = 32'd2251799813;

    localparam logic REG_WHEEL_RADIUS  = 1'b0;
    localparam logic REG_INVERSE_TRACK = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MA,
        ST_MB,
        ST_RND,
        ST_MC,
        ST_MD,
        ST_ME,
        ST_ADD,
        ST_MID,
        ST_MG,
        ST_ABS,
        ST_QEST,
        ST_QMUL,
        ST_QSUB,
        ST_QFIX,
        ST_CWAIT,
        ST_MX,
        ST_MZ,
        ST_UPX,
        ST_FIN
    } ddo_state_t;

    typedef struct packed {
        logic               busy;
        logic signed [33:0] sin_v;
        logic signed [33:0] cos_v;
    } ddo_trig_t;

    // arctangent of 2^-i in binary angle units
    function automatic logic [31:0] atan_bau(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051D;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2E;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2F9;
            5'd15:   v = 32'h0000517C;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A2F;
            5'd19:   v = 32'h00000517;
            5'd20:   v = 32'h0000028B;
            5'd21:   v = 32'h00000145;
            5'd22:   v = 32'h000000A2;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/ddo_cordic.sv
// rotation-mode cordic giving sine and cosine of a binary angle
`timescale 1ns / 1ps

module ddo_cordic
    import ddo_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] angle,
    output ddo_trig_t   trig
);

    localparam int CW = $clog2(CORDIC_STEPS);

    logic signed [33:0] x_reg;
    logic signed [33:0] y_reg;
    logic signed [33:0] z_reg;
    logic [CW-1:0]      cnt_reg;
    logic               busy_reg;
    logic               flip_reg;

    logic signed [33:0] xs;
    logic signed [33:0] ys;
    logic signed [33:0] at;
    logic               flip_in;

    assign xs      = x_reg >>> cnt_reg;
    assign ys      = y_reg >>> cnt_reg;
    assign at      = $signed({2'b00, atan_bau(5'(cnt_reg))});
    assign flip_in = angle[31] ^ angle[30];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == CW'(CORDIC_STEPS - 1))
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            // fold the left half plane onto the right one
            flip_reg <= flip_in;
            x_reg    <= $signed(CORDIC_GAIN);
            y_reg    <= '0;
            z_reg    <= $signed({{3{angle[31] ^ flip_in}}, angle[30:0]});
        end
        else if (busy_reg)
        begin
            if (!z_reg[33])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
        end
    end

    assign trig.busy  = busy_reg;
    assign trig.sin_v = flip_reg ? -y_reg : y_reg;
    assign trig.cos_v = flip_reg ? -x_reg : x_reg;

endmodule

// File: hw/rtl/differential_drive_odometry_unit.sv
// odometry pose update: heading, x and z from wheel rates and interval
//
//  channel  direction  handshake           payload
//  in       to block   in_valid/in_stall   left_rate, right_rate, elapsed_time
//  out      from block out_valid/out_stall heading, pos_x, pos_z
//  cfg      to block   apb psel/penable    wheel_radius @0, inverse_track @4
//
// a transaction first forms the rate and angle products (ST_MA to ST_MG), then the cordic
// runs while the distance is divided by a reciprocal product with one correction step,
// then the final products, pose update and output load follow (ST_MX to ST_FIN)
// in_stall is high from acceptance until the result sits in the output register
// the result waits there under out_stall; the next transaction may start meanwhile
// reset zeroes the pose and loads the default geometry
`timescale 1ns / 1ps
`include "assert_macros.svh"

module differential_drive_odometry_unit
    import ddo_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] left_rate,
    input  logic signed [15:0] right_rate,
    input  logic [19:0]        elapsed_time,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [31:0]        heading,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_z,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    ddo_state_t state_reg, state_next;

    logic [15:0]        wr_reg;
    logic [23:0]        it_reg;
    logic [31:0]        heading_reg;
    logic signed [31:0] x_reg;
    logic signed [31:0] z_reg;

    logic signed [15:0] l_reg;
    logic signed [15:0] r_reg;
    logic [19:0]        dt_reg;
    logic signed [57:0] prod_reg;
    logic signed [32:0] omega_reg;
    logic signed [25:0] hi_reg;
    logic [52:0]        lo_reg;
    logic [31:0]        dth_reg;
    logic [31:0]        mid_reg;
    logic [52:0]        rem_reg;
    logic               neg_reg;
    logic [23:0]        q_reg;
    logic signed [24:0] dist_reg;
    logic signed [33:0] sn_reg;
    logic signed [33:0] cs_reg;
    logic signed [27:0] dx_reg;

    logic [31:0]        out_heading_reg;
    logic signed [31:0] out_x_reg;
    logic signed [31:0] out_z_reg;
    logic               out_valid_reg;

    logic signed [33:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [67:0] mul_p;
    logic               cordic_start;
    logic               load_out;
    ddo_trig_t          trig;

    logic               cfg_wr;
    logic [16:0]        diff17;
    logic [16:0]        sum17;
    logic [57:0]        rnd_omega;
    logic [57:0]        rnd_d;
    logic signed [27:0] d_round;
    logic [63:0]        turn_t;
    logic [52:0]        p53;
    logic [52:0]        div_k;
    logic               div_ge;
    logic [31:0]        head_new;
    logic signed [31:0] z_new;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [27:0] d);
        logic [32:0] s;
        s = {a[31], a} + {{5{d[27]}}, d};
        if (s[32] != s[31])
        begin
            return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return $signed(s[31:0]);
    endfunction

    ddo_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .angle (mid_reg),
        .trig  (trig)
    );

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_INVERSE_TRACK) ? {8'b0, it_reg} : {16'b0, wr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= WHEEL_RADIUS_RST;
            it_reg <= INVERSE_TRACK_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_WHEEL_RADIUS:  wr_reg <= pwdata[15:0];
                REG_INVERSE_TRACK: it_reg <= pwdata[23:0];
                default:           wr_reg <= wr_reg;
            endcase
        end
    end

    // shared multiplier operand selection
    assign diff17 = {l_reg[15], l_reg} - {r_reg[15], r_reg};
    assign sum17  = {l_reg[15], l_reg} + {r_reg[15], r_reg};

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MA:
            begin
                mul_a = $signed({{17{diff17[16]}}, diff17});
                mul_b = $signed({18'b0, wr_reg});
            end
            ST_MB:
            begin
                mul_a = prod_reg[33:0];
                mul_b = $signed({10'b0, it_reg});
            end
            ST_MC:
            begin
                mul_a = $signed({omega_reg[32], omega_reg});
                mul_b = $signed({14'b0, dt_reg});
            end
            ST_MD:
            begin
                mul_a = $signed({7'b0, prod_reg[26:0]});
                mul_b = $signed({8'b0, TURN_SCALE});
            end
            ST_ME:
            begin
                mul_a = $signed({{8{hi_reg[25]}}, hi_reg});
                mul_b = $signed({8'b0, TURN_SCALE});
            end
            ST_MID:
            begin
                mul_a = $signed({{17{sum17[16]}}, sum17});
                mul_b = $signed({18'b0, wr_reg});
            end
            ST_MG:
            begin
                mul_a = prod_reg[33:0];
                mul_b = $signed({14'b0, dt_reg});
            end
            ST_QEST:
            begin
                mul_a = $signed({3'b0, rem_reg[52:22]});
                mul_b = $signed({2'b0, DIV_RECIP});
            end
            ST_QMUL:
            begin
                mul_a = $signed({10'b0, q_reg});
                mul_b = $signed({5'b0, DIST_DIV});
            end
            ST_MX:
            begin
                mul_a = $signed({{9{dist_reg[24]}}, dist_reg});
                mul_b = sn_reg;
            end
            ST_MZ:
            begin
                mul_a = $signed({{9{dist_reg[24]}}, dist_reg});
                mul_b = cs_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // datapath helpers
    assign rnd_omega = prod_reg + 58'sd8388608;
    assign rnd_d     = prod_reg + 58'sd536870912;
    assign d_round   = $signed(rnd_d[57:30]);
    assign turn_t    = {11'b0, lo_reg} + ({{6{prod_reg[57]}}, prod_reg} << 27)
                       + 64'h0000_0000_8000_0000;
    assign p53       = prod_reg[52:0];
    assign div_k     = {24'b0, DIST_DIV};
    assign div_ge    = rem_reg >= div_k;
    assign head_new  = heading_reg + dth_reg;
    assign z_new     = sat_add(z_reg, dx_reg);

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cordic_start = 1'b0;
        load_out     = 1'b0;
        case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_MA;
            ST_MA:    state_next = ST_MB;
            ST_MB:    state_next = ST_RND;
            ST_RND:   state_next = ST_MC;
            ST_MC:    state_next = ST_MD;
            ST_MD:    state_next = ST_ME;
            ST_ME:    state_next = ST_ADD;
            ST_ADD:   state_next = ST_MID;
            ST_MID:   state_next = ST_MG;
            ST_MG:
            begin
                cordic_start = 1'b1;
                state_next   = ST_ABS;
            end
            ST_ABS:   state_next = ST_QEST;
            ST_QEST:  state_next = ST_QMUL;
            ST_QMUL:  state_next = ST_QSUB;
            ST_QSUB:  state_next = ST_QFIX;
            ST_QFIX:  state_next = ST_CWAIT;
            ST_CWAIT: if (!trig.busy) state_next = ST_MX;
            ST_MX:    state_next = ST_MZ;
            ST_MZ:    state_next = ST_UPX;
            ST_UPX:   state_next = ST_FIN;
            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

    // pose accumulators and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heading_reg   <= '0;
            x_reg         <= '0;
            z_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_UPX)
            begin
                x_reg <= sat_add(x_reg, dx_reg);
            end
            if (load_out)
            begin
                heading_reg   <= head_new;
                z_reg         <= z_new;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_heading_reg <= head_new;
            out_x_reg       <= x_reg;
            out_z_reg       <= z_new;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        prod_reg <= $signed(mul_p[57:0]);
        case (state_reg)
            ST_IDLE:
            begin
                l_reg  <= left_rate;
                r_reg  <= right_rate;
                dt_reg <= elapsed_time;
            end
            ST_RND:
            begin
                omega_reg <= $signed(rnd_omega[56:24]);
            end
            ST_MD:
            begin
                hi_reg <= $signed(prod_reg[52:27]);
            end
            ST_ME:
            begin
                lo_reg <= prod_reg[52:0];
            end
            ST_ADD:
            begin
                dth_reg <= turn_t[63:32];
            end
            ST_MID:
            begin
                // midpoint heading: half the signed change
                mid_reg <= heading_reg + {dth_reg[31], dth_reg[31:1]};
            end
            ST_ABS:
            begin
                neg_reg <= p53[52];
                rem_reg <= p53[52] ? (DIST_HALF - p53) : (p53 + DIST_HALF);
            end
            ST_QEST:
            begin
                // quotient estimate, low by at most one
                q_reg <= mul_p[61:38];
            end
            ST_QSUB:
            begin
                rem_reg <= rem_reg - prod_reg[52:0];
            end
            ST_QFIX:
            begin
                if (div_ge)
                begin
                    q_reg <= q_reg + 1'b1;
                end
            end
            ST_CWAIT:
            begin
                dist_reg <= neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
                sn_reg   <= trig.sin_v;
                cs_reg   <= trig.cos_v;
            end
            ST_MZ:
            begin
                dx_reg <= d_round;
            end
            ST_UPX:
            begin
                dx_reg <= d_round;
            end
            default:
            begin
                dx_reg <= dx_reg;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign heading   = out_heading_reg;
    assign pos_x     = out_x_reg;
    assign pos_z     = out_z_reg;

    `DDO_ASSERT_RST(a_accept_starts, (in_valid && !in_stall) |=> (state_reg == ST_MA), "accepted transaction did not start the sequence")
    `DDO_ASSERT_RST(a_result_from_fin, $rose(out_valid) |-> ($past(state_reg) == ST_FIN), "result raised outside the final step")
    `DDO_ASSERT_RST(a_cordic_in_window, trig.busy |-> (state_reg >= ST_ABS && state_reg <= ST_CWAIT), "cordic busy outside its window")
    `DDO_ASSERT_ALWAYS(a_reset_quiet, (!rst_n) |-> (!out_valid && !trig.busy && !in_stall), "block not quiet in reset")

endmodule
